// ===== src/vr_pkg.sv =====
package vr_pkg;

	localparam int VR_ITERATIONS = 16;
	localparam int VR_DATA_WIDTH = 16;
	localparam int VR_ANGLE_W    = 16;
	// angle accumulator, 2^32 units per turn
	localparam int VR_Z_W        = 32;
	localparam int VR_TAB_LEN    = 24;
	// cordic gain 0.60725..., q0.24
	localparam logic [23:0] VR_GAIN_Q24 = 24'd10187994;
	localparam int VR_GAIN_W     = 25;

	// headroom below the input lsb
	function automatic int vr_guard(input int dw);
		int g;
		g = (dw <= 24) ? 12 : (36 - dw);
		return g;
	endfunction

	// atan(2^-i) in accumulator units, rounded to nearest
	function automatic logic [VR_Z_W-1:0] vr_atan(input int i);
		logic [VR_Z_W-1:0] v;
		unique case (i)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/vr_prerot.sv =====
module vr_prerot #(
	parameter int DW    = 16,
	parameter int GUARD = 12,
	parameter int IW    = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DW-1:0]                in_x,
	input  logic signed [DW-1:0]                in_y,
	input  logic [vr_pkg::VR_ANGLE_W-1:0]       angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [IW-1:0]                out_x,
	output logic signed [IW-1:0]                out_y,
	output logic signed [vr_pkg::VR_Z_W-1:0]    out_z
);
	import vr_pkg::*;

	logic [VR_ANGLE_W-1:0] a_bias;
	logic [1:0]            quad;
	logic [VR_ANGLE_W-1:0] resid;
	logic signed [IW-1:0]  x_ext, y_ext, x_rot, y_rot;
	logic                  v_q;
	logic signed [IW-1:0]  x_q, y_q;
	logic signed [VR_Z_W-1:0] z_q;

	// nearest quarter turn, residual within +-1/8 turn
	assign a_bias = angle + VR_ANGLE_W'(16'h2000);
	assign quad   = a_bias[VR_ANGLE_W-1 -: 2];
	assign resid  = angle - {quad, {(VR_ANGLE_W-2){1'b0}}};

	assign x_ext = {{(IW-DW){in_x[DW-1]}}, in_x} <<< GUARD;
	assign y_ext = {{(IW-DW){in_y[DW-1]}}, in_y} <<< GUARD;

	// exact quarter-turn rotation
	always_comb begin
		unique case (quad)
			2'd1: begin
				x_rot = -y_ext;
				y_rot = x_ext;
			end
			2'd2: begin
				x_rot = -x_ext;
				y_rot = -y_ext;
			end
			2'd3: begin
				x_rot = y_ext;
				y_rot = -x_ext;
			end
			default: begin
				x_rot = x_ext;
				y_rot = y_ext;
			end
		endcase
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_q <= x_rot;
			y_q <= y_rot;
			z_q <= {resid, {(VR_Z_W-VR_ANGLE_W){1'b0}}};
		end
	end

	assign out_valid = v_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

// ===== src/vr_cell.sv =====
module vr_cell #(
	parameter int IW    = 30,
	parameter int SHIFT = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [IW-1:0]                in_x,
	input  logic signed [IW-1:0]                in_y,
	input  logic signed [vr_pkg::VR_Z_W-1:0]    in_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [IW-1:0]                out_x,
	output logic signed [IW-1:0]                out_y,
	output logic signed [vr_pkg::VR_Z_W-1:0]    out_z
);
	import vr_pkg::*;

	localparam logic signed [VR_Z_W-1:0] ATAN = vr_atan(SHIFT);

	logic signed [IW-1:0]     xs, ys;
	logic                     ccw;
	logic                     v_q;
	logic signed [IW-1:0]     x_q, y_q;
	logic signed [VR_Z_W-1:0] z_q;

	// floor shifts; zero residual turns counterclockwise
	assign xs  = in_x >>> SHIFT;
	assign ys  = in_y >>> SHIFT;
	assign ccw = !in_z[VR_Z_W-1];

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (ccw) begin
				x_q <= in_x - ys;
				y_q <= in_y + xs;
				z_q <= in_z - ATAN;
			end else begin
				x_q <= in_x + ys;
				y_q <= in_y - xs;
				z_q <= in_z + ATAN;
			end
		end
	end

	assign out_valid = v_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

// ===== src/vr_gain.sv =====
module vr_gain #(
	parameter int DW    = 16,
	parameter int GUARD = 12,
	parameter int IW    = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [IW-1:0] in_x,
	input  logic signed [IW-1:0] in_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] out_x,
	output logic signed [DW-1:0] out_y
);
	import vr_pkg::*;

	localparam int PW = IW + VR_GAIN_W;
	localparam int SH = 24 + GUARD;
	localparam logic signed [VR_GAIN_W-1:0] GAIN = {1'b0, VR_GAIN_Q24};
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (SH - 1);
	localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< (DW - 1)) - PW'(1);
	localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

	logic                 v_s1, v_s2;
	logic                 rdy_s1, rdy_s2;
	logic signed [PW-1:0] px_s1, py_s1;
	logic signed [PW-1:0] rx, ry;
	logic signed [DW-1:0] sx, sy;
	logic signed [DW-1:0] x_s2, y_s2;

	// round half up, then clamp to the output range
	function automatic logic signed [DW-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [DW-1:0] r;
		priority if (v > MAXV) begin
			r = MAXV[DW-1:0];
		end else if (v < MINV) begin
			r = MINV[DW-1:0];
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

	assign rx = (px_s1 + HALF) >>> SH;
	assign ry = (py_s1 + HALF) >>> SH;
	assign sx = sat(rx);
	assign sy = sat(ry);

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			px_s1 <= PW'(in_x) * PW'(GAIN);
			py_s1 <= PW'(in_y) * PW'(GAIN);
		end
		if (rdy_s2 && v_s1) begin
			x_s2 <= sx;
			y_s2 <= sy;
		end
	end

	assign out_valid = v_s2;
	assign out_x     = x_s2;
	assign out_y     = y_s2;

endmodule

// ===== src/vector_rotator.sv =====
// path: pre-rotation register, then the cell registers, then the gain registers
// throughput: one item per cycle, set by the unrolled chain of micro-rotation cells
// every stage has its own valid flag and takes a new item whenever it is empty or
// its successor moves on, so gaps close up under output back-pressure
// reset: arst_n clears all valid flags asynchronously, datapath registers are not reset
module vector_rotator #(
	parameter int ITERATIONS = vr_pkg::VR_ITERATIONS,
	parameter int DATA_WIDTH = vr_pkg::VR_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	// input item channel
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// in_x, in_y, angle (16 bits), zero padding to whole bytes
	input  logic [((2*DATA_WIDTH+vr_pkg::VR_ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
	// result item channel
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_x, out_y, zero padding to whole bytes
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
	import vr_pkg::*;

	localparam int DW     = DATA_WIDTH;
	localparam int GUARD  = vr_guard(DW);
	// two bits of headroom: quadrant negation and cordic growth of about 1.65
	localparam int IW     = DW + GUARD + 2;
	// never more cells than the arctangent table has entries
	localparam int NCELLS = (ITERATIONS < VR_TAB_LEN) ? ITERATIONS : VR_TAB_LEN;
	localparam int OUT_TW = ((2*DW+7)/8)*8;

	// unpacked input fields
	logic signed [DW-1:0]     in_x, in_y;
	logic [VR_ANGLE_W-1:0]    angle;

	// links between cells: index 0 is the pre-rotation output
	logic                     c_valid [0:NCELLS];
	logic                     c_ready [0:NCELLS];
	logic signed [IW-1:0]     c_x     [0:NCELLS];
	logic signed [IW-1:0]     c_y     [0:NCELLS];
	logic signed [VR_Z_W-1:0] c_z     [0:NCELLS];

	logic signed [DW-1:0]     out_x, out_y;

	assign in_x  = s_axis_tdata[DW-1:0];
	assign in_y  = s_axis_tdata[2*DW-1:DW];
	assign angle = s_axis_tdata[2*DW +: VR_ANGLE_W];

	// quadrant pre-rotation, leaves a residual within +-1/8 turn
	vr_prerot #(
		.DW    (DW),
		.GUARD (GUARD),
		.IW    (IW)
	) u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_x      (in_x),
		.in_y      (in_y),
		.angle     (angle),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.out_x     (c_x[0]),
		.out_y     (c_y[0]),
		.out_z     (c_z[0])
	);

	// one micro-rotation per cell, cell i shifts by i
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		vr_cell #(
			.IW    (IW),
			.SHIFT (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_x      (c_x[i]),
			.in_y      (c_y[i]),
			.in_z      (c_z[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_x     (c_x[i+1]),
			.out_y     (c_y[i+1]),
			.out_z     (c_z[i+1])
		);
	end

	// gain removal, rounding and saturation; the last stage is the output register
	// the residual angle of the last cell is not needed
	vr_gain #(
		.DW    (DW),
		.GUARD (GUARD),
		.IW    (IW)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid[NCELLS]),
		.in_ready  (c_ready[NCELLS]),
		.in_x      (c_x[NCELLS]),
		.in_y      (c_y[NCELLS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (out_x),
		.out_y     (out_y)
	);

	assign m_axis_tdata = OUT_TW'({out_y, out_x});

endmodule

// ===== src/vr_checker.sv =====
module vr_checker #(
	parameter int DATA_WIDTH = vr_pkg::VR_DATA_WIDTH
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((2*DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// with the output drained every cycle the pipeline never pushes back
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled although output is free");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result present straight after reset");

endmodule

bind vector_rotator vr_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_vr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
